// ----- rtl/fvg_pkg.sv -----
// ----------------------------------------------------------------------------
// FAT volume geometry package
// Field widths, request and result layouts, FAT type codes and thresholds.
// ----------------------------------------------------------------------------
package fvg_pkg;

    localparam int BPS_W      = 16;
    localparam int SPC_W      = 8;
    localparam int SEC_W      = 32;
    localparam int DIR_SHIFT  = 5;
    localparam int ROOT_NUM_W = BPS_W + DIR_SHIFT + 1;

    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;
    localparam logic [1:0] KIND_FAT32 = 2'd2;

    localparam logic [SEC_W-1:0] FAT12_LIMIT = 32'd4085;
    localparam logic [SEC_W-1:0] FAT16_LIMIT = 32'd65525;

    typedef struct packed {
        logic [31:0] partition_start;
        logic [31:0] fat_size_large;
        logic [31:0] total_sectors_large;
        logic [15:0] fat_size_small;
        logic [15:0] total_sectors_small;
        logic [15:0] root_entry_count;
        logic [7:0]  fat_copies;
        logic [15:0] reserved_sectors;
        logic [7:0]  sectors_per_cluster;
        logic [15:0] bytes_per_sector;
    } t_in;

    typedef struct packed {
        logic [3:0]       pad;
        logic [SEC_W-1:0] data_first_sector;
        logic [SEC_W-1:0] root_dir_first_sector;
        logic [SEC_W-1:0] cluster_count;
        logic [SEC_W-1:0] data_sector_count;
        logic [SEC_W-1:0] total_sector_count;
        logic [SEC_W-1:0] fat_size_used;
        logic [SEC_W-1:0] root_dir_sector_count;
        logic             invalid;
        logic             supported;
        logic [1:0]       fat_kind;
    } t_out;

    typedef struct packed {
        logic [SEC_W-1:0] base;
        logic [SEC_W-1:0] fsz;
        logic [SEC_W-1:0] total;
        logic [SEC_W-1:0] prod;
        logic [BPS_W-1:0] rsv;
        logic [SPC_W-1:0] spc;
        logic             bps_zero;
    } t_front;

    typedef struct packed {
        logic [SEC_W-1:0] root;
        logic [SEC_W-1:0] fsz;
        logic [SEC_W-1:0] total;
        logic [SEC_W-1:0] data;
        logic [SEC_W-1:0] root_first;
        logic [SEC_W-1:0] data_first;
        logic             bad;
    } t_mid;

    localparam int FRONT_W = $bits(t_front);
    localparam int MID_W   = $bits(t_mid);

endpackage

// ----- rtl/fvg_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: shift in a dividend bit, trial subtract,
// emit one quotient bit; the request and its side data are registered with it.
// ----------------------------------------------------------------------------
module fvg_div_cell #(
    parameter int NW = fvg_pkg::SEC_W,
    parameter int DW = fvg_pkg::SPC_W,
    parameter int SW = fvg_pkg::MID_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  logic [DW-1:0] i_rem,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic [DW-1:0] o_rem,
    output logic [NW-1:0] o_num,
    output logic [DW-1:0] o_div,
    output logic [SW-1:0] o_side
);

    logic          r_valid;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_div;
    logic [SW-1:0] r_side;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_fit;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_num;

    assign w_trial = {i_rem, i_num[NW-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_fit   = (w_trial >= {1'b0, i_div});
    assign n_rem   = w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
    assign n_num   = {i_num[NW-2:0], w_fit};

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            r_rem   <= n_rem;
            r_num   <= n_num;
            r_div   <= i_div;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

// ----- rtl/fvg_div_chain.sv -----
// ----------------------------------------------------------------------------
// Divider chain
// A row of NW divider cells; one quotient bit per cell, one request per cycle while not stalled.
// ----------------------------------------------------------------------------
module fvg_div_chain #(
    parameter int NW = fvg_pkg::SEC_W,
    parameter int DW = fvg_pkg::SPC_W,
    parameter int SW = fvg_pkg::MID_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [NW-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    logic [NW:0]          w_valid;
    logic [NW:0]          w_ready;
    logic [NW:0][DW-1:0]  w_rem;
    logic [NW:0][NW-1:0]  w_num;
    logic [NW:0][DW-1:0]  w_div;
    logic [NW:0][SW-1:0]  w_side;

    assign w_valid[0] = i_valid;
    assign o_ready    = w_ready[0];
    assign w_rem[0]   = '0;
    assign w_num[0]   = i_num;
    assign w_div[0]   = i_div;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < NW; g++) begin : g_cell
        fvg_div_cell #(
            .NW (NW),
            .DW (DW),
            .SW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .i_rem   (w_rem[g]),
            .i_num   (w_num[g]),
            .i_div   (w_div[g]),
            .i_side  (w_side[g]),
            .o_rem   (w_rem[g+1]),
            .o_num   (w_num[g+1]),
            .o_div   (w_div[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign w_ready[NW] = i_ready;
    assign o_valid     = w_valid[NW];
    assign o_quot      = w_num[NW];
    assign o_side      = w_side[NW];

endmodule

// ----- rtl/fvg_join.sv -----
// ----------------------------------------------------------------------------
// Layout join
// Two stages: sum the overhead, then check it against the total and form the
// data region size and the absolute first sectors.
// ----------------------------------------------------------------------------
module fvg_join (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  fvg_pkg::t_front               i_front,
    input  logic [fvg_pkg::SEC_W-1:0]     i_root,
    output logic                          o_valid,
    input  logic                          i_ready,
    output fvg_pkg::t_mid                 o_mid,
    output logic [fvg_pkg::SPC_W-1:0]     o_div
);

    typedef struct packed {
        logic [fvg_pkg::SEC_W-1:0] fats_end;
        logic [fvg_pkg::SEC_W-1:0] overhead;
        logic [fvg_pkg::SEC_W-1:0] root;
        logic [fvg_pkg::SEC_W-1:0] fsz;
        logic [fvg_pkg::SEC_W-1:0] total;
        logic [fvg_pkg::SEC_W-1:0] base;
        logic [fvg_pkg::SPC_W-1:0] spc;
        logic                      bps_zero;
    } t_sum;

    logic                      r_av;
    t_sum                      r_a;
    logic                      r_bv;
    fvg_pkg::t_mid             r_b;
    logic [fvg_pkg::SPC_W-1:0] r_div;

    logic                      w_en_a;
    logic                      w_en_b;
    t_sum                      n_a;
    fvg_pkg::t_mid             n_b;
    logic [fvg_pkg::SEC_W-1:0] w_fats_end;

    assign w_en_b  = !r_bv || i_ready;
    assign w_en_a  = !r_av || w_en_b;
    assign o_ready = w_en_a;

    assign w_fats_end = {{(fvg_pkg::SEC_W-fvg_pkg::BPS_W){1'b0}}, i_front.rsv} + i_front.prod;

    always_comb begin
        n_a.fats_end = w_fats_end;
        n_a.overhead = w_fats_end + i_root;
        n_a.root     = i_root;
        n_a.fsz      = i_front.fsz;
        n_a.total    = i_front.total;
        n_a.base     = i_front.base;
        n_a.spc      = i_front.spc;
        n_a.bps_zero = i_front.bps_zero;
    end

    always_comb begin
        n_b.bad        = r_a.bps_zero || (r_a.spc == '0) || (r_a.overhead > r_a.total);
        n_b.root       = r_a.root;
        n_b.fsz        = r_a.fsz;
        n_b.total      = r_a.total;
        n_b.data       = n_b.bad ? '0 : (r_a.total - r_a.overhead);
        n_b.root_first = r_a.base + r_a.fats_end;
        n_b.data_first = r_a.base + r_a.overhead;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_av <= i_valid;
                r_a  <= n_a;
            end
            if (w_en_b) begin
                r_bv  <= r_av;
                r_b   <= n_b;
                r_div <= (r_a.spc == '0) ? fvg_pkg::SPC_W'(1) : r_a.spc;
            end
        end
    end

    assign o_valid = r_bv;
    assign o_mid   = r_b;
    assign o_div   = r_div;

endmodule

// ----- rtl/fat_volume_geometry.sv -----
// ----------------------------------------------------------------------------
// FAT volume geometry
// Works out the layout and FAT type of a volume from its parameter block.
// ----------------------------------------------------------------------------
// Slave stream s_axis carries one parameter block per request; the master
// stream m_axis returns one layout result per request, in order.
// Path: an input stage selects the FAT size and total count and forms
// copies * FAT size; a row of 22 divider cells yields the root directory
// sector count; two join stages sum the overhead, check it and form the
// first sectors; a row of 32 divider cells yields the cluster count; an
// output register classifies the type and holds the result.
// One request is taken per cycle while the row is not held full by a low
// m_axis_tready, since every cell and stage then passes its contents on.
// Each register frees when its successor can take, so bubbles close
// up while m_axis_tready is low and requests are still taken until the
// whole row is full. Reset empties every stage; no results are in flight.
// ----------------------------------------------------------------------------
module fat_volume_geometry (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bytes_per_sector, sectors_per_cluster, reserved_sectors, fat_copies,
    // root_entry_count, total_sectors_small, fat_size_small,
    // total_sectors_large, fat_size_large, partition_start
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fat_kind, supported, invalid, root_dir_sector_count, fat_size_used,
    // total_sector_count, data_sector_count, cluster_count,
    // root_dir_first_sector, data_first_sector, zero fill
    output logic [231:0] m_axis_tdata
);

    localparam int RNW = fvg_pkg::ROOT_NUM_W;
    localparam int SW  = fvg_pkg::SEC_W;

    fvg_pkg::t_in              w_in;
    logic                      r_fv;
    fvg_pkg::t_front           r_front;
    logic [RNW-1:0]            r_num;
    logic [fvg_pkg::BPS_W-1:0] r_bps;
    fvg_pkg::t_front           n_front;
    logic [SW-1:0]             w_fsz;
    logic [SW+fvg_pkg::SPC_W-1:0] w_prod;
    logic                      w_en_f;

    logic                      w_c1_ready;
    logic                      w_c1_valid;
    logic [RNW-1:0]            w_c1_quot;
    logic [fvg_pkg::FRONT_W-1:0] w_c1_side;

    logic                      w_j_ready;
    logic                      w_j_valid;
    fvg_pkg::t_mid             w_j_mid;
    logic [fvg_pkg::SPC_W-1:0] w_j_div;

    logic                      w_c2_ready;
    logic                      w_c2_valid;
    logic [SW-1:0]             w_c2_quot;
    logic [fvg_pkg::MID_W-1:0] w_c2_side;
    fvg_pkg::t_mid             w_mid;

    logic                      r_ov;
    fvg_pkg::t_out             r_out;
    fvg_pkg::t_out             n_out;
    logic                      w_en_o;

    assign w_in = fvg_pkg::t_in'(s_axis_tdata);

    assign w_fsz  = (w_in.fat_size_small != '0) ?
                    {{(SW-16){1'b0}}, w_in.fat_size_small} : w_in.fat_size_large;
    assign w_prod = w_in.fat_copies * w_fsz;

    always_comb begin
        n_front.base     = w_in.partition_start;
        n_front.fsz      = w_fsz;
        n_front.total    = (w_in.total_sectors_small != '0) ?
                           {{(SW-16){1'b0}}, w_in.total_sectors_small} :
                           w_in.total_sectors_large;
        n_front.prod     = w_prod[SW-1:0];
        n_front.rsv      = w_in.reserved_sectors;
        n_front.spc      = w_in.sectors_per_cluster;
        n_front.bps_zero = (w_in.bytes_per_sector == '0);
    end

    assign w_en_f        = !r_fv || w_c1_ready;
    assign s_axis_tready = w_en_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_en_f) begin
            r_fv    <= s_axis_tvalid;
            r_front <= n_front;
            if (w_in.bytes_per_sector == '0) begin
                r_num <= '0;
                r_bps <= fvg_pkg::BPS_W'(1);
            end else begin
                r_num <= {1'b0, w_in.root_entry_count, {fvg_pkg::DIR_SHIFT{1'b0}}}
                         + {{(RNW-fvg_pkg::BPS_W){1'b0}}, w_in.bytes_per_sector}
                         - {{(RNW-1){1'b0}}, 1'b1};
                r_bps <= w_in.bytes_per_sector;
            end
        end
    end

    fvg_div_chain #(
        .NW (RNW),
        .DW (fvg_pkg::BPS_W),
        .SW (fvg_pkg::FRONT_W)
    ) u_root_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fv),
        .o_ready (w_c1_ready),
        .i_num   (r_num),
        .i_div   (r_bps),
        .i_side  (r_front),
        .o_valid (w_c1_valid),
        .i_ready (w_j_ready),
        .o_quot  (w_c1_quot),
        .o_side  (w_c1_side)
    );

    fvg_join u_join (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c1_valid),
        .o_ready (w_j_ready),
        .i_front (fvg_pkg::t_front'(w_c1_side)),
        .i_root  ({{(SW-RNW){1'b0}}, w_c1_quot}),
        .o_valid (w_j_valid),
        .i_ready (w_c2_ready),
        .o_mid   (w_j_mid),
        .o_div   (w_j_div)
    );

    fvg_div_chain #(
        .NW (SW),
        .DW (fvg_pkg::SPC_W),
        .SW (fvg_pkg::MID_W)
    ) u_clus_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_j_valid),
        .o_ready (w_c2_ready),
        .i_num   (w_j_mid.data),
        .i_div   (w_j_div),
        .i_side  (w_j_mid),
        .o_valid (w_c2_valid),
        .i_ready (w_en_o),
        .o_quot  (w_c2_quot),
        .o_side  (w_c2_side)
    );

    assign w_mid = fvg_pkg::t_mid'(w_c2_side);

    always_comb begin
        n_out.pad                   = '0;
        n_out.invalid               = w_mid.bad;
        n_out.root_dir_sector_count = w_mid.root;
        n_out.fat_size_used         = w_mid.fsz;
        n_out.total_sector_count    = w_mid.total;
        n_out.data_sector_count     = w_mid.data;
        n_out.cluster_count         = w_mid.bad ? '0 : w_c2_quot;
        n_out.root_dir_first_sector = w_mid.root_first;
        n_out.data_first_sector     = w_mid.data_first;
        priority if (w_mid.bad || (w_c2_quot < fvg_pkg::FAT12_LIMIT)) begin
            n_out.fat_kind = fvg_pkg::KIND_FAT12;
        end else if (w_c2_quot < fvg_pkg::FAT16_LIMIT) begin
            n_out.fat_kind = fvg_pkg::KIND_FAT16;
        end else begin
            n_out.fat_kind = fvg_pkg::KIND_FAT32;
        end
        n_out.supported = !w_mid.bad && (n_out.fat_kind == fvg_pkg::KIND_FAT16);
    end

    assign w_en_o = !r_ov || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en_o) begin
            r_ov  <= w_c2_valid;
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    a_supported_fat16: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.supported) |->
        (r_out.fat_kind == fvg_pkg::KIND_FAT16 && !r_out.invalid))
        else $error("supported result not a valid FAT16 volume");

    a_invalid_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.invalid) |->
        (r_out.data_sector_count == '0 && r_out.cluster_count == '0 &&
         r_out.fat_kind == fvg_pkg::KIND_FAT12))
        else $error("invalid result carries non-zero counts");

    a_data_after_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out.data_first_sector ==
                  r_out.root_dir_first_sector + r_out.root_dir_sector_count))
        else $error("data region does not follow the root directory");

    a_fat12_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_out.invalid) |->
        ((r_out.fat_kind == fvg_pkg::KIND_FAT12) ==
         (r_out.cluster_count < fvg_pkg::FAT12_LIMIT)))
        else $error("FAT12 class disagrees with cluster count");

endmodule

// ----- verif/fvg_checker.sv -----
// ----------------------------------------------------------------------------
// FAT volume geometry checker
// Watches both streams of the geometry block. Each accepted parameter block
// is turned into an expected layout. Each returned layout is compared, field
// by field, with the oldest expected one. Mismatches and unexpected results
// are counted for the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvg_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_tvalid,
    input  logic         i_req_tready,
    input  logic [191:0] i_req_tdata,
    input  logic         i_res_tvalid,
    input  logic         i_res_tready,
    input  logic [231:0] i_res_tdata,
    output int           o_fail_count,
    output int           o_pending
);

    localparam logic [fvg_pkg::SEC_W-1:0] DIR_ENTRY_BYTES = 32'd32;

    fvg_pkg::t_out layout_q[$];
    int            fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic fvg_pkg::t_out predict_layout(input fvg_pkg::t_in blk);
        logic [fvg_pkg::SEC_W-1:0] root;
        logic [fvg_pkg::SEC_W-1:0] fsz;
        logic [fvg_pkg::SEC_W-1:0] total;
        logic [fvg_pkg::SEC_W-1:0] fats_end;
        logic [fvg_pkg::SEC_W-1:0] overhead;
        logic [fvg_pkg::SEC_W-1:0] clusters;
        logic                      bad;
        fvg_pkg::t_out             res;
        root = '0;
        if (blk.bytes_per_sector != 0) begin
            root = (32'(blk.root_entry_count) * DIR_ENTRY_BYTES
                    + 32'(blk.bytes_per_sector) - 32'd1) / 32'(blk.bytes_per_sector);
        end
        fsz      = (blk.fat_size_small != 0) ? 32'(blk.fat_size_small) : blk.fat_size_large;
        total    = (blk.total_sectors_small != 0) ? 32'(blk.total_sectors_small)
                                                  : blk.total_sectors_large;
        fats_end = 32'(blk.reserved_sectors) + 32'(blk.fat_copies) * fsz;
        overhead = fats_end + root;
        bad      = (blk.bytes_per_sector == 0) || (blk.sectors_per_cluster == 0)
                   || (overhead > total);
        res = '0;
        res.invalid               = bad;
        res.root_dir_sector_count = root;
        res.fat_size_used         = fsz;
        res.total_sector_count    = total;
        res.root_dir_first_sector = blk.partition_start + fats_end;
        res.data_first_sector     = blk.partition_start + overhead;
        res.fat_kind              = fvg_pkg::KIND_FAT12;
        if (!bad) begin
            res.data_sector_count = total - overhead;
            clusters              = res.data_sector_count / 32'(blk.sectors_per_cluster);
            res.cluster_count     = clusters;
            if (clusters < fvg_pkg::FAT12_LIMIT) begin
                res.fat_kind = fvg_pkg::KIND_FAT12;
            end else if (clusters < fvg_pkg::FAT16_LIMIT) begin
                res.fat_kind = fvg_pkg::KIND_FAT16;
            end else begin
                res.fat_kind = fvg_pkg::KIND_FAT32;
            end
            res.supported = (res.fat_kind == fvg_pkg::KIND_FAT16);
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [fvg_pkg::SEC_W-1:0] want,
                               input logic [fvg_pkg::SEC_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        fvg_pkg::t_out want;
        fvg_pkg::t_out got;
        if (i_rst_n) begin
            if (i_req_tvalid && i_req_tready) begin
                layout_q.push_back(predict_layout(fvg_pkg::t_in'(i_req_tdata)));
            end
            if (i_res_tvalid && i_res_tready) begin
                if (layout_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = layout_q.pop_front();
                    got  = fvg_pkg::t_out'(i_res_tdata[$bits(fvg_pkg::t_out)-1:0]);
                    check_field("fat_kind", 32'(want.fat_kind), 32'(got.fat_kind));
                    check_field("supported", 32'(want.supported), 32'(got.supported));
                    check_field("invalid", 32'(want.invalid), 32'(got.invalid));
                    check_field("root_dir_sector_count", want.root_dir_sector_count,
                                got.root_dir_sector_count);
                    check_field("fat_size_used", want.fat_size_used, got.fat_size_used);
                    check_field("total_sector_count", want.total_sector_count,
                                got.total_sector_count);
                    check_field("data_sector_count", want.data_sector_count,
                                got.data_sector_count);
                    check_field("cluster_count", want.cluster_count, got.cluster_count);
                    check_field("root_dir_first_sector", want.root_dir_first_sector,
                                got.root_dir_first_sector);
                    check_field("data_first_sector", want.data_first_sector,
                                got.data_first_sector);
                end
            end
        end
        o_pending = layout_q.size();
    end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// FAT volume geometry testbench
// Sends directed parameter blocks (field extremes, zero sizes, overhead at
// and beyond the total, type thresholds, address wrap), then random blocks:
// mostly well-formed volumes near and between the type thresholds, some
// broken ones and some raw noise. Sender gaps and receiver stalls vary by
// phase; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_PER_PHASE = 100;
    localparam int DRAIN_CYCLES     = 64;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [231:0] m_axis_tdata;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count;
    int pending;

    fat_volume_geometry u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fvg_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_tvalid (s_axis_tvalid),
        .i_req_tready (s_axis_tready),
        .i_req_tdata  (s_axis_tdata),
        .i_res_tvalid (m_axis_tvalid),
        .i_res_tready (m_axis_tready),
        .i_res_tdata  (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // total is sized so that exactly the requested clusters fit
    function automatic fvg_pkg::t_in build_volume(
        input int unsigned bps, input int unsigned spc, input int unsigned rsv,
        input int unsigned copies, input int unsigned entries, input int unsigned fsz,
        input int unsigned clusters, input int unsigned slack, input int unsigned base,
        input bit small_tot, input bit small_fsz);
        fvg_pkg::t_in blk;
        int unsigned  root;
        int unsigned  total;
        root  = (entries * 32 + bps - 1) / bps;
        total = rsv + copies * fsz + root + clusters * spc + slack;
        blk.bytes_per_sector    = 16'(bps);
        blk.sectors_per_cluster = 8'(spc);
        blk.reserved_sectors    = 16'(rsv);
        blk.fat_copies          = 8'(copies);
        blk.root_entry_count    = 16'(entries);
        blk.partition_start     = base;
        blk.fat_size_large      = $urandom();
        blk.total_sectors_large = $urandom();
        if (small_fsz && fsz != 0 && fsz < 65536) begin
            blk.fat_size_small = 16'(fsz);
        end else begin
            blk.fat_size_small = '0;
            blk.fat_size_large = fsz;
        end
        if (small_tot && total != 0 && total < 65536) begin
            blk.total_sectors_small = 16'(total);
        end else begin
            blk.total_sectors_small = '0;
            blk.total_sectors_large = total;
        end
        return blk;
    endfunction

    function automatic fvg_pkg::t_in random_block();
        int unsigned  pick;
        int unsigned  spc;
        int unsigned  clusters;
        fvg_pkg::t_in blk;
        pick = $urandom_range(99);
        spc  = 1 << $urandom_range(0, 7);
        case ($urandom_range(0, 5))
            0:       clusters = $urandom_range(1, 4084);
            1:       clusters = $urandom_range(4080, 4090);
            2:       clusters = $urandom_range(4085, 65524);
            3:       clusters = $urandom_range(65520, 65530);
            4:       clusters = $urandom_range(65525, 1 << 21);
            default: clusters = $urandom_range(0, 10);
        endcase
        blk = build_volume(128 << $urandom_range(0, 5), spc, $urandom_range(1, 64),
                           $urandom_range(1, 2),
                           $urandom_range(0, 1) ? 0 : $urandom_range(16, 1024),
                           $urandom_range(1, 600), clusters, $urandom_range(0, spc - 1),
                           $urandom_range(0, 1) ? $urandom_range(0, 4096) : $urandom(),
                           $urandom_range(0, 1), $urandom_range(0, 1));
        if (pick < 20) begin
            blk = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        end else if (pick < 35) begin
            case ($urandom_range(0, 2))
                0:       blk.bytes_per_sector = '0;
                1:       blk.sectors_per_cluster = '0;
                default: begin
                    blk = build_volume(512, spc, $urandom_range(1, 64), 2,
                                       $urandom_range(0, 512), $urandom_range(1, 600), 0, 0,
                                       $urandom(), 1'b0, $urandom_range(0, 1));
                    blk.total_sectors_large = blk.total_sectors_large - 1;
                end
            endcase
        end
        return blk;
    endfunction

    task automatic send_request(input fvg_pkg::t_in blk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        fvg_pkg::t_in blk;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request('0);
        send_request('1);
        blk = build_volume(512, 4, 1, 2, 512, 9, 3000, 0, 63, 1'b1, 1'b1);
        blk.bytes_per_sector = '0;
        send_request(blk);
        blk = build_volume(512, 4, 1, 2, 512, 9, 3000, 0, 63, 1'b1, 1'b1);
        blk.sectors_per_cluster = '0;
        send_request(blk);
        // overhead equal to the total, then one beyond it
        send_request(build_volume(512, 1, 1, 2, 512, 9, 0, 0, 0, 1'b1, 1'b1));
        blk = build_volume(512, 1, 1, 2, 512, 9, 0, 0, 0, 1'b0, 1'b1);
        blk.total_sectors_large = blk.total_sectors_large - 1;
        send_request(blk);
        send_request(build_volume(512, 1, 1, 2, 512, 12, 4084, 0, 2048, 1'b1, 1'b1));
        send_request(build_volume(512, 1, 1, 2, 512, 12, 4085, 0, 2048, 1'b1, 1'b1));
        send_request(build_volume(512, 2, 4, 2, 512, 256, 65524, 1, 2048, 1'b0, 1'b1));
        send_request(build_volume(512, 2, 32, 2, 0, 512, 65525, 1, 2048, 1'b0, 1'b0));
        send_request(build_volume(4096, 128, 32, 2, 0, 8000, 1 << 20, 127, 32'hFFFF_FFF0,
                                  1'b0, 1'b0));
        send_request(build_volume(1, 1, 65535, 1, 65535, 65535, 100, 0, 0, 1'b0, 1'b1));
        send_request(build_volume(65535, 255, 0, 255, 1, 1, 5000, 254, 7, 1'b0, 1'b1));
        // FAT area wraps past 32 bits
        send_request(build_volume(512, 1, 32, 2, 0, 32'h8000_0000, 100, 0, 0, 1'b0, 1'b0));
        send_request(build_volume(512, 8, 1, 1, 224, 3, 300, 7, 32'hFFFF_FFFF, 1'b1, 1'b0));
        send_request(build_volume(2048, 64, 6, 2, 512, 60, 30000, 0, 1, 1'b0, 1'b1));

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 63 : (phase == 3) ? 18 : 0;
            recv_stall_pct = (phase == 2) ? 63 : (phase == 3) ? 18 : 0;
            repeat (RANDOM_PER_PHASE) send_request(random_block());
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
